@@ hw/rtl/steim_frame_decoder_top_macros.svh @@
// assertion macros for the steim frame decoder
// used by steim_frame_decoder_top, needs clk and rst_n in scope
`ifndef STEIM_FRAME_DECODER_TOP_MACROS_SVH
`define STEIM_FRAME_DECODER_TOP_MACROS_SVH

// condition must lead to consequence in the same cycle
`define STEIM_FD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must lead to consequence in the next cycle
`define STEIM_FD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/steim_fd_pkg.sv @@
// shared types and constants of the steim frame decoder
// no dependencies
package steim_fd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_WIDTH   = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = '1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam logic [1:0] STEIM1_LEVEL = 2'd1;

    typedef enum logic [1:0] {
        CFG_STEIM_LEVEL = 2'd0,
        CFG_SWAP_BYTES  = 2'd1,
        CFG_MAX_SAMPLES = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_FIRST,
        CMD_LAST,
        CMD_DIFF,
        CMD_SUMMARY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] word;
        logic [5:0]  bits;
        logic [4:0]  shift;
    } cmd_t;

    typedef enum logic {
        BK_FIRST,
        BK_NEXT
    } bk_state_t;

endpackage

@@ hw/rtl/steim_fd_in_if.sv @@
// input channel of the steim frame decoder: one frame word or an end request
// no dependencies
interface steim_fd_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        start_record;
    logic [31:0] word_bits;

    modport source (output valid, output req_type, output start_record, output word_bits,
                    input ready);
    modport sink   (input valid, input req_type, input start_record, input word_bits,
                    output ready);
endinterface

@@ hw/rtl/steim_fd_out_if.sv @@
// output channel of the steim frame decoder: one sample or summary per transfer
// no dependencies
interface steim_fd_out_if;
    logic               valid;
    logic               ready;
    logic               is_summary;
    logic signed [31:0] sample_value;
    logic               last_of_run;
    logic [15:0]        sample_count;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;

    modport source (output valid, output is_summary, output sample_value, output last_of_run,
                    output sample_count, output first_value, output last_value,
                    input ready);
    modport sink   (input valid, input is_summary, input sample_value, input last_of_run,
                    input sample_count, input first_value, input last_value,
                    output ready);
endinterface

@@ hw/rtl/steim_fd_front.sv @@
// front end: tracks frame position and control word, classifies each word
// depends on steim_fd_pkg and steim_fd_in_if
module steim_fd_front (
    input  logic                clk,
    input  logic                rst_n,
    steim_fd_in_if.sink         in_ch,
    input  logic [1:0]          steim_level,
    input  logic                swap_bytes,
    output steim_fd_pkg::cmd_t  cmd,
    output logic                cmd_valid,
    input  logic                cmd_ready
);
    import steim_fd_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [31:0] cw_reg, cw_next;
    logic        first_reg, first_next;

    logic [31:0] w;
    logic [3:0]  pos;
    logic        first;
    logic [1:0]  code;
    logic [1:0]  top;
    logic [4:0]  code_sh;
    logic        accept;

    assign in_ch.ready = cmd_ready;
    assign cmd_valid   = in_ch.valid;
    assign accept      = in_ch.valid && cmd_ready;

    always_comb
    begin
        w = swap_bytes ? {in_ch.word_bits[7:0], in_ch.word_bits[15:8],
                          in_ch.word_bits[23:16], in_ch.word_bits[31:24]}
                       : in_ch.word_bits;
        pos     = in_ch.start_record ? 4'd0 : pos_reg;
        first   = in_ch.start_record ? 1'b1 : first_reg;
        code_sh = {4'(4'd15 - pos), 1'b0};
        code    = 2'(cw_reg >> code_sh);
        top     = w[31:30];

        cmd.kind  = CMD_NONE;
        cmd.word  = w;
        cmd.bits  = 6'd0;
        cmd.shift = 5'd0;

        pos_next   = pos_reg;
        cw_next    = cw_reg;
        first_next = first_reg;

        if (in_ch.req_type)
        begin
            cmd.kind = CMD_SUMMARY;
        end
        else
        begin
            if (pos == 4'd0)
            begin
                cw_next  = w;
                cmd.kind = in_ch.start_record ? CMD_CLEAR : CMD_NONE;
            end
            else if (first && pos == 4'd1)
            begin
                cmd.kind = CMD_FIRST;
            end
            else if (first && pos == 4'd2)
            begin
                cmd.kind = CMD_LAST;
            end
            else if (code != 2'd0)
            begin
                cmd.kind = CMD_DIFF;
                if (code == 2'd1)
                begin
                    cmd.bits = 6'd8;  cmd.shift = 5'd24;
                end
                else if (steim_level == STEIM1_LEVEL)
                begin
                    if (code == 2'd2)
                    begin
                        cmd.bits = 6'd16; cmd.shift = 5'd16;
                    end
                    else
                    begin
                        cmd.bits = 6'd32; cmd.shift = 5'd0;
                    end
                end
                else if (code == 2'd2)
                begin
                    case (top)
                        2'd2:    begin cmd.bits = 6'd15; cmd.shift = 5'd15; end
                        2'd3:    begin cmd.bits = 6'd10; cmd.shift = 5'd20; end
                        default: begin cmd.bits = 6'd30; cmd.shift = 5'd0;  end
                    endcase
                end
                else
                begin
                    case (top)
                        2'd1:    begin cmd.bits = 6'd5; cmd.shift = 5'd25; end
                        2'd2:    begin cmd.bits = 6'd4; cmd.shift = 5'd24; end
                        default: begin cmd.bits = 6'd6; cmd.shift = 5'd24; end
                    endcase
                end
            end
            pos_next   = 4'(pos + 4'd1);
            first_next = (pos_next == 4'd0) ? 1'b0 : first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            cw_reg    <= 32'd0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            cw_reg    <= cw_next;
            first_reg <= first_next;
        end
    end

endmodule

@@ hw/rtl/steim_fd_queue.sv @@
// short command queue between front and back end
// depends on steim_fd_pkg
module steim_fd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  steim_fd_pkg::cmd_t  wr_cmd,
    input  logic                wr_valid,
    output logic                wr_ready,
    output steim_fd_pkg::cmd_t  rd_cmd,
    output logic                rd_valid,
    input  logic                rd_pop
);
    import steim_fd_pkg::*;

    cmd_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_WIDTH:0]   fill_reg, fill_next;
    logic                  push, pop;

    assign wr_ready = (fill_reg != (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hw/rtl/steim_fd_back.sv @@
// back end: unpacks differences one a cycle while the output register is free, integrates, drives the output register
// depends on steim_fd_pkg and steim_fd_out_if
module steim_fd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  steim_fd_pkg::cmd_t  head,
    input  logic                head_valid,
    output logic                head_pop,
    input  logic [15:0]         max_samples,
    steim_fd_out_if.source      out_ch
);
    import steim_fd_pkg::*;

    bk_state_t              state_reg, state_next;
    logic [4:0]             shift_reg, shift_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [31:0]            run_reg, run_next;
    logic [31:0]            start_reg, start_next;
    logic [31:0]            end_reg, end_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   o_sum_reg, o_sum_next;
    logic [31:0]            o_val_reg, o_val_next;
    logic                   o_last_reg, o_last_next;
    logic [15:0]            o_cnt_reg, o_cnt_next;
    logic [31:0]            o_first_reg, o_first_next;
    logic [31:0]            o_end_reg, o_end_next;

    logic                   can_emit;
    logic [4:0]             cur_shift;
    logic [31:0]            field;
    logic [31:0]            aligned;
    logic [5:0]             ext_amt;
    logic [31:0]            diff;
    logic [31:0]            sample;
    logic                   at_cap, next_cap, done;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.is_summary   = o_sum_reg;
    assign out_ch.sample_value = o_val_reg;
    assign out_ch.last_of_run  = o_last_reg;
    assign out_ch.sample_count = o_cnt_reg;
    assign out_ch.first_value  = o_first_reg;
    assign out_ch.last_value   = o_end_reg;

    always_comb
    begin
        can_emit  = !out_valid_reg || out_ch.ready;
        cur_shift = (state_reg == BK_FIRST) ? head.shift : shift_reg;
        field     = head.word >> cur_shift;
        ext_amt   = 6'(6'd32 - head.bits);
        aligned   = field << ext_amt;
        diff      = 32'($signed(aligned) >>> ext_amt);
        sample    = (cnt_reg == '0) ? start_reg : 32'(run_reg + diff);
        at_cap    = (CMP_WIDTH'(cnt_reg) >= CMP_WIDTH'(max_samples)) || (cnt_reg == COUNT_LIMIT);
        next_cap  = ((CMP_WIDTH'(cnt_reg) + CMP_WIDTH'(1)) >= CMP_WIDTH'(max_samples))
                    || (cnt_reg == COUNT_WIDTH'(COUNT_LIMIT - 1'b1));
        done      = (cur_shift == 5'd0) || next_cap;

        state_next = state_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        start_next = start_reg;
        end_next   = end_reg;
        head_pop   = 1'b0;

        out_valid_next = out_valid_reg && !out_ch.ready;
        o_sum_next     = o_sum_reg;
        o_val_next     = o_val_reg;
        o_last_next    = o_last_reg;
        o_cnt_next     = o_cnt_reg;
        o_first_next   = o_first_reg;
        o_end_next     = o_end_reg;

        if (head_valid)
        begin
            unique case (head.kind)
                CMD_NONE:
                begin
                    head_pop = 1'b1;
                end
                CMD_CLEAR:
                begin
                    cnt_next   = '0;
                    run_next   = 32'd0;
                    start_next = 32'd0;
                    end_next   = 32'd0;
                    head_pop   = 1'b1;
                end
                CMD_FIRST:
                begin
                    start_next = head.word;
                    head_pop   = 1'b1;
                end
                CMD_LAST:
                begin
                    end_next = head.word;
                    head_pop = 1'b1;
                end
                CMD_SUMMARY:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        o_sum_next     = 1'b1;
                        o_val_next     = run_reg;
                        o_last_next    = 1'b1;
                        o_cnt_next     = 16'(cnt_reg);
                        o_first_next   = start_reg;
                        o_end_next     = end_reg;
                        head_pop       = 1'b1;
                    end
                end
                CMD_DIFF:
                begin
                    if (can_emit)
                    begin
                        if (at_cap)
                        begin
                            // cap reached: the rest of the word is dropped
                            head_pop   = 1'b1;
                            state_next = BK_FIRST;
                        end
                        else
                        begin
                            cnt_next       = cnt_reg + 1'b1;
                            run_next       = sample;
                            out_valid_next = 1'b1;
                            o_sum_next     = 1'b0;
                            o_val_next     = sample;
                            o_last_next    = done;
                            o_cnt_next     = 16'(cnt_reg + 1'b1);
                            o_first_next   = start_reg;
                            o_end_next     = end_reg;
                            if (done)
                            begin
                                head_pop   = 1'b1;
                                state_next = BK_FIRST;
                            end
                            else
                            begin
                                shift_next = 5'(6'(cur_shift) - head.bits);
                                state_next = BK_NEXT;
                            end
                        end
                    end
                end
                default:
                begin
                    head_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FIRST;
            shift_reg     <= 5'd0;
            cnt_reg       <= '0;
            run_reg       <= 32'd0;
            start_reg     <= 32'd0;
            end_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            cnt_reg       <= cnt_next;
            run_reg       <= run_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_sum_reg   <= o_sum_next;
        o_val_reg   <= o_val_next;
        o_last_reg  <= o_last_next;
        o_cnt_reg   <= o_cnt_next;
        o_first_reg <= o_first_next;
        o_end_reg   <= o_end_next;
    end

endmodule

@@ hw/rtl/steim_frame_decoder_top.sv @@
// steim1/steim2 frame decoder top: config registers, front end, queue, back end
// path: a taken word is stored in the queue, then the back end writes its result into the output register
// throughput: the front takes one word a cycle until the queue fills; the back end emits one sample per cycle
//   while the output register is free (up to 7 per data word) and retires one other word per cycle
// reset: asynchronous active low, config back to steim2 / no swap / cap 65535, record state cleared
`include "steim_frame_decoder_top_macros.svh"

module steim_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    steim_fd_in_if.sink     in_ch,
    steim_fd_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import steim_fd_pkg::*;

    // configuration registers; the user must write them only while the decoder is idle, the block does not enforce this
    logic [1:0]  steim_level_reg;
    logic        swap_bytes_reg;
    logic [15:0] max_samples_reg;

    // front to queue, queue to back
    cmd_t        front_cmd;
    logic        front_valid;
    logic        front_ready;
    cmd_t        head_cmd;
    logic        head_valid;
    logic        head_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steim_level_reg <= 2'd2;
            swap_bytes_reg  <= 1'b0;
            max_samples_reg <= 16'hffff;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STEIM_LEVEL: steim_level_reg <= cfg_data[1:0];
                CFG_SWAP_BYTES:  swap_bytes_reg  <= cfg_data[0];
                CFG_MAX_SAMPLES: max_samples_reg <= cfg_data;
                default:         ;  // writes beyond the register list are ignored
            endcase
        end
    end

    // front end: word position, control word, per-word classification
    steim_fd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .steim_level (steim_level_reg),
        .swap_bytes  (swap_bytes_reg),
        .cmd         (front_cmd),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready)
    );

    // decouples word intake from sample emission
    steim_fd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_cmd   (head_cmd),
        .rd_valid (head_valid),
        .rd_pop   (head_pop)
    );

    // back end: difference unpacking, integration, sample cap, output register
    steim_fd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .max_samples (max_samples_reg),
        .out_ch      (out_ch)
    );

    // the back end only retires a queue entry that is present
    `STEIM_FD_ASSERT_IMP(a_pop_needs_head, head_pop, head_valid, "queue popped while empty")
    // a sample transfer always carries a count of at least one within the cap
    `STEIM_FD_ASSERT_IMP(a_sample_count_range, out_ch.valid && !out_ch.is_summary,
        (out_ch.sample_count != 16'd0) && (out_ch.sample_count <= max_samples_reg),
        "sample count outside the cap")
    // a summary is a single-result run
    `STEIM_FD_ASSERT_IMP(a_summary_last, out_ch.valid && out_ch.is_summary,
        out_ch.last_of_run, "summary without last flag")
    // a full queue stays full in the next cycle unless the back end pops an entry
    `STEIM_FD_ASSERT_NXT(a_front_stall, in_ch.valid && !front_ready && !head_pop,
        !front_ready, "queue full flag dropped without a pop")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for steim_frame_decoder_top: well-formed steim1/steim2 records
// and noise go in, every sample and summary transfer is checked against a built-in decoder
// depends on steim_fd_pkg, steim_fd_in_if, steim_fd_out_if and the decoder rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import steim_fd_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 12;     // queue depth plus back end, with margin
    localparam int HOLD_CYCLES  = 200;    // long receiver hold-off in the last phase
    localparam int QUIET_LIMIT  = 2000;   // cycles without any transfer before giving up
    localparam int END_QUIET    = 1000;

    localparam logic [1:0] STEIM2_LEVEL = 2'd2;

    // request kinds on the word channel
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // 2-bit codes of the control word
    localparam logic [1:0] CODE_BYTES = 2'd1;
    localparam logic [1:0] CODE_MID   = 2'd2;
    localparam logic [1:0] CODE_WIDE  = 2'd3;

    // steim2 nibble (top two bits of the data word) under code 2
    localparam logic [1:0] MID_RESERVED = 2'd0;
    localparam logic [1:0] MID_ONE30    = 2'd1;
    localparam logic [1:0] MID_TWO15    = 2'd2;
    localparam logic [1:0] MID_THREE10  = 2'd3;

    // steim2 nibble under code 3
    localparam logic [1:0] WIDE_FIVE6    = 2'd0;
    localparam logic [1:0] WIDE_SIX5     = 2'd1;
    localparam logic [1:0] WIDE_SEVEN4   = 2'd2;
    localparam logic [1:0] WIDE_RESERVED = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic        start_record;
        logic [31:0] word_bits;
    } frame_word_t;

    typedef struct packed {
        logic               is_summary;
        logic signed [31:0] sample_value;
        logic               last_of_run;
        logic [15:0]        sample_count;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
    } sample_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    steim_fd_in_if  word_ch ();
    steim_fd_out_if sample_ch ();

    steim_frame_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (word_ch),
        .out_ch    (sample_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // words waiting for the driver, samples waiting for the dut
    frame_word_t    pending_words[$];
    sample_result_t expected_samples[$];
    sample_result_t word_run[$];

    int words_offered;
    int words_taken;
    int phase_words;
    int errors;
    int quiet_cycles;
    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_req;
    int hold_cycles;

    // decoder copy: registers
    logic [1:0]  level_reg;
    logic        swap_reg;
    logic [15:0] cap_reg;

    // decoder copy: record state
    logic [3:0]             word_pos;
    logic [31:0]            ctrl_word;
    logic                   first_frame;
    logic [31:0]            first_val;
    logic [31:0]            last_val;
    logic [31:0]            cur_sample;
    logic [COUNT_WIDTH-1:0] diff_count;

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [31:0] byte_swap(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] sext_field(input logic [31:0] w, input int shift,
                                               input int nbits);
        logic [31:0] mask;
        logic [31:0] v;
        if (nbits >= 32)
            return w;
        mask = (32'd1 << nbits) - 32'd1;
        v = (w >> shift) & mask;
        if (v[nbits-1])
            v = v | ~mask;
        return v;
    endfunction

    // one difference: the first of a record is replaced by the first value,
    // anything past the cap is dropped without a sample
    function automatic void accept_difference(input logic [31:0] d);
        if (diff_count >= cap_reg || diff_count == COUNT_LIMIT)
            return;
        if (diff_count == 0)
            cur_sample = first_val;
        else
            cur_sample = cur_sample + d;
        diff_count++;
        word_run.push_back('{1'b0, cur_sample, 1'b0, diff_count, first_val, last_val});
    endfunction

    // expected samples for one accepted transfer on the word channel
    function automatic void decode_word(input frame_word_t item);
        logic [31:0] w;
        logic [1:0]  code;
        logic [1:0]  top;
        int          nbits;
        int          nfields;
        word_run.delete();
        if (item.req_type == REQ_END)
        begin
            // summary only, record state untouched, start mark ignored
            expected_samples.push_back('{1'b1, cur_sample, 1'b1, diff_count, first_val,
                                         last_val});
            return;
        end
        w = swap_reg ? byte_swap(item.word_bits) : item.word_bits;
        if (item.start_record)
        begin
            word_pos    = '0;
            first_frame = 1'b1;
            diff_count  = '0;
            cur_sample  = '0;
            first_val   = '0;
            last_val    = '0;
        end
        if (word_pos == 0)
            ctrl_word = w;
        else if (first_frame && word_pos == 1)
            first_val = w;
        else if (first_frame && word_pos == 2)
            last_val = w;
        else
        begin
            code    = 2'(ctrl_word >> (2 * (15 - int'(word_pos))));
            top     = w[31:30];
            nbits   = 0;
            nfields = 0;
            if (code == CODE_BYTES)
            begin
                nbits = 8; nfields = 4;
            end
            else if (level_reg == STEIM1_LEVEL)
            begin
                if (code == CODE_MID)
                begin
                    nbits = 16; nfields = 2;
                end
                else if (code == CODE_WIDE)
                begin
                    nbits = 32; nfields = 1;
                end
            end
            else if (code == CODE_MID)
            begin
                // reserved nibble falls back to one 30-bit difference
                case (top)
                    MID_TWO15:   begin nbits = 15; nfields = 2; end
                    MID_THREE10: begin nbits = 10; nfields = 3; end
                    default:     begin nbits = 30; nfields = 1; end
                endcase
            end
            else if (code == CODE_WIDE)
            begin
                // reserved nibble falls back to five 6-bit differences
                case (top)
                    WIDE_SIX5:   begin nbits = 5; nfields = 6; end
                    WIDE_SEVEN4: begin nbits = 4; nfields = 7; end
                    default:     begin nbits = 6; nfields = 5; end
                endcase
            end
            for (int i = 0; i < nfields; i++)
                accept_difference(sext_field(w, (nfields - 1 - i) * nbits, nbits));
        end
        word_pos = word_pos + 4'd1;
        if (word_pos == 0)
            first_frame = 1'b0;
        if (word_run.size() != 0)
            word_run[word_run.size() - 1].last_of_run = 1'b1;
        foreach (word_run[i])
            expected_samples.push_back(word_run[i]);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------

    // words are stored as the dut must see them on the wire, so the
    // byte swap is undone here when it is switched on
    function automatic void push_word(input logic req, input logic start, input logic [31:0] w);
        pending_words.push_back('{req, start, swap_reg ? byte_swap(w) : w});
        phase_words++;
    endfunction

    // data word that fits its code; steim2 nibbles are legal most of the time
    function automatic logic [31:0] make_data_word(input logic [1:0] code);
        logic [31:0] w;
        w = $urandom;
        if (level_reg != STEIM1_LEVEL)
        begin
            if (code == CODE_MID)
                w[31:30] = ($urandom_range(9) == 0) ? MID_RESERVED
                                                    : 2'($urandom_range(MID_THREE10, MID_ONE30));
            else if (code == CODE_WIDE)
                w[31:30] = ($urandom_range(9) == 0) ? WIDE_RESERVED
                                                    : 2'($urandom_range(WIDE_SEVEN4, WIDE_FIVE6));
        end
        return w;
    endfunction

    // a record of whole frames, cut short after nwords words when asked
    function automatic void queue_record(input int nframes, input int nwords, input bit with_end);
        logic [31:0] ctrl;
        logic [31:0] w;
        int          sent;
        sent = 0;
        for (int f = 0; f < nframes && sent < nwords; f++)
        begin
            ctrl = $urandom;
            push_word(REQ_DATA, f == 0, ctrl);
            sent++;
            for (int k = 1; k < 16 && sent < nwords; k++)
            begin
                if (f == 0 && k <= 2)
                begin
                    // integration constants, often at the extremes
                    case ($urandom_range(3))
                        0:       w = 32'h8000_0000;
                        1:       w = 32'h7fff_ffff;
                        default: w = $urandom;
                    endcase
                end
                else
                    w = make_data_word(ctrl[31 - 2 * k -: 2]);
                push_word(REQ_DATA, 1'b0, w);
                sent++;
            end
        end
        if (with_end)
            push_word(REQ_END, 1'($urandom_range(1)), $urandom);
    endfunction

    // mostly proper records, the rest stray words, stray starts and end requests
    function automatic void queue_random(input int nwords);
        int frames;
        phase_words = 0;
        while (phase_words < nwords)
        begin
            if ($urandom_range(9) < 7)
            begin
                frames = ($urandom_range(3) == 0) ? 2 : 1;
                queue_record(frames,
                             ($urandom_range(3) == 0) ? $urandom_range(16 * frames, 1)
                                                      : 16 * frames,
                             $urandom_range(4) != 0);
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                    push_word(($urandom_range(3) == 0) ? REQ_END : REQ_DATA,
                              $urandom_range(7) == 0, $urandom);
            end
        end
    endfunction

    // hand-picked record under the reset settings (steim2, no swap, no cap)
    function automatic void queue_directed();
        // end request before any record: zero summary, start mark ignored
        push_word(REQ_END, 1'b1, 32'hffff_ffff);
        // frame 0 control: words 1-2 carry codes that must be ignored, then
        // 3 bytes, 4 one30, 5 two15, 6 three10, 7 five6, 8 six5, 9 seven4,
        // 10 reserved code-2 nibble, 11 reserved code-3 nibble, 12 none,
        // 13 bytes, 14 code 2, 15 code 3
        push_word(REQ_DATA, 1'b1, 32'h35ab_fb1b);
        push_word(REQ_DATA, 1'b0, 32'h8000_0000);   // first value, most negative
        push_word(REQ_DATA, 1'b0, 32'h7fff_ffff);   // last value, most positive
        push_word(REQ_DATA, 1'b0, 32'h7f80_017f);
        push_word(REQ_DATA, 1'b0, 32'h5fff_ffff);
        push_word(REQ_DATA, 1'b0, 32'h9fff_c000);
        push_word(REQ_DATA, 1'b0, 32'hdff8_03ff);
        push_word(REQ_DATA, 1'b0, 32'h2082_0820);
        push_word(REQ_DATA, 1'b0, 32'h7fff_ffff);
        push_word(REQ_DATA, 1'b0, 32'h8777_7777);
        push_word(REQ_DATA, 1'b0, 32'h2aaa_aaaa);
        push_word(REQ_DATA, 1'b0, 32'hffff_ffff);
        push_word(REQ_DATA, 1'b0, 32'h1234_5678);
        push_word(REQ_DATA, 1'b0, 32'h8080_8080);
        push_word(REQ_DATA, 1'b0, 32'ha5a5_a5a5);
        push_word(REQ_DATA, 1'b0, 32'hc000_0000);
        // summary mid-record, the record then carries on into frame 1
        push_word(REQ_END, 1'b0, 32'h0000_0000);
        push_word(REQ_DATA, 1'b0, 32'h5555_5555);
        push_word(REQ_DATA, 1'b0, 32'hffff_ffff);
        push_word(REQ_DATA, 1'b0, 32'h0000_0000);
        // short record: control and first value only
        push_word(REQ_DATA, 1'b1, 32'hffff_ffff);
        push_word(REQ_DATA, 1'b0, 32'hdead_beef);
        push_word(REQ_END, 1'b0, 32'h0f0f_0f0f);
    endfunction

    // ---------------------------------------------------------------
    // configuration, only ever called with the decoder idle
    // ---------------------------------------------------------------

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_config(input logic [1:0] level, input logic swap, input logic [15:0] cap);
        write_reg(CFG_STEIM_LEVEL, {14'd0, level});
        write_reg(CFG_SWAP_BYTES, {15'd0, swap});
        write_reg(CFG_MAX_SAMPLES, cap);
        level_reg = level;
        swap_reg  = swap;
        cap_reg   = cap;
    endtask

    // every word taken, every sample seen, then let trailing non-emitting words finish
    task automatic wait_idle();
        while (pending_words.size() != 0 || words_offered != words_taken ||
               expected_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // word driver: one word held until its transfer, gaps only between words
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin: word_driver
        frame_word_t item;
        if (rst_n && words_offered == words_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                item = pending_words.pop_front();
                word_ch.valid        <= 1'b1;
                word_ch.req_type     <= item.req_type;
                word_ch.start_record <= item.start_record;
                word_ch.word_bits    <= item.word_bits;
                words_offered++;
            end
            else
                word_ch.valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // sample sink: random back-pressure plus one long hold-off when asked
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin: sample_sink
        if (hold_req && hold_cycles < HOLD_CYCLES)
        begin
            hold_cycles++;
            sample_ch.ready <= 1'b0;
        end
        else
            sample_ch.ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // ---------------------------------------------------------------
    // transfer monitor: check samples first, then predict for a taken word
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin: transfer_monitor
        sample_result_t want;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample transfer with nothing expected: value %0h",
                       sample_ch.sample_value);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                check_field("is_summary", 32'(want.is_summary), 32'(sample_ch.is_summary));
                check_field("sample_value", want.sample_value, sample_ch.sample_value);
                check_field("last_of_run", 32'(want.last_of_run), 32'(sample_ch.last_of_run));
                check_field("sample_count", 32'(want.sample_count),
                            32'(sample_ch.sample_count));
                check_field("first_value", want.first_value, sample_ch.first_value);
                check_field("last_value", want.last_value, sample_ch.last_value);
            end
        end
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            decode_word('{word_ch.req_type, word_ch.start_record, word_ch.word_bits});
            words_taken++;
        end
    end

    // watchdog: any transfer on either side restarts the count
    always @(posedge clk)
    begin: watchdog
        if ((word_ch.valid && word_ch.ready) || (sample_ch.valid && sample_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial
    begin: stimulus
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_STEIM_LEVEL;
        cfg_data             = '0;
        word_ch.valid        = 1'b0;
        word_ch.req_type     = REQ_DATA;
        word_ch.start_record = 1'b0;
        word_ch.word_bits    = '0;
        sample_ch.ready      = 1'b0;
        words_offered        = 0;
        words_taken          = 0;
        errors               = 0;
        quiet_cycles         = 0;
        hold_req             = 1'b0;
        hold_cycles          = 0;

        // decoder copy at its reset values
        level_reg   = STEIM2_LEVEL;
        swap_reg    = 1'b0;
        cap_reg     = 16'hffff;
        word_pos    = '0;
        ctrl_word   = '0;
        first_frame = 1'b1;
        first_val   = '0;
        last_val    = '0;
        cur_sample  = '0;
        diff_count  = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        sender_idle_pct   = 29;
        receiver_idle_pct = 76;
        queue_directed();
        wait_idle();

        // steim1 with the full cap, 32-bit differences included
        set_config(STEIM1_LEVEL, 1'b0, 16'hffff);
        queue_random(45);
        wait_idle();

        // steim2, swapped bytes, cap cuts into longer records
        set_config(STEIM2_LEVEL, 1'b1, 16'd40);
        queue_random(45);
        wait_idle();

        // roles of the two sides swapped
        sender_idle_pct   = 76;
        receiver_idle_pct = 29;

        // cap of zero: only summaries come out
        set_config(STEIM2_LEVEL, 1'b0, 16'd0);
        queue_random(25);
        wait_idle();

        // steim1, swapped, tiny cap
        set_config(STEIM1_LEVEL, 1'b1, 16'd7);
        queue_random(45);
        wait_idle();

        // full rate both sides, with the sink holding off long enough
        // for the decoder to fill and stall its input
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_config(STEIM2_LEVEL, 1'b0, 16'hffff);
        queue_random(45);
        hold_req = 1'b1;

        while (pending_words.size() != 0 || words_offered != words_taken)
            @(negedge clk);
        while (expected_samples.size() != 0 && quiet_cycles < END_QUIET)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_samples.size() != 0)
        begin
            $error("%0d expected samples never arrived", expected_samples.size());
            errors++;
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/steim_fd_pkg.sv
hw/rtl/steim_fd_in_if.sv
hw/rtl/steim_fd_out_if.sv
hw/rtl/steim_fd_front.sv
hw/rtl/steim_fd_queue.sv
hw/rtl/steim_fd_back.sv
hw/rtl/steim_frame_decoder_top.sv
tb/tb.sv
